### rtl/ml_decoder_linear_block_code_macros.svh
// assertion helpers shared by the checker files
`ifndef ML_DECODER_LINEAR_BLOCK_CODE_MACROS_SVH
`define ML_DECODER_LINEAR_BLOCK_CODE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MLDLBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define MLDLBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mldlbc_pkg.sv
package mldlbc_pkg;

  localparam int unsigned NLong  = 31;
  localparam int unsigned KLong  = 16;
  localparam int unsigned NShort = 15;
  localparam int unsigned KShort = 7;

  localparam logic [15:0] CandLastLong  = 16'((1 << KLong) - 1);
  localparam logic [15:0] CandLastShort = 16'((1 << KShort) - 1);

  // starting best distance, above any reachable distance
  localparam logic [7:0] DistStart = 8'd233;

  typedef logic [NLong-1:0]  long_row_t;
  typedef logic [NShort-1:0] short_row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // generator rows, bit j is code position j
  localparam long_row_t GenLong [KLong] = '{
    31'b010_0111111_1000011_0000001_0000001,
    31'b001_0010101_0000010_0100001_0000010,
    31'b010_0100011_0000010_0100001_0000100,
    31'b000_1111010_1000001_0100001_0001000,
    31'b011_0110100_1000001_0100001_0010000,
    31'b111_1101001_1000011_0000001_0100000,
    31'b101_0101110_0000000_0000001_1000000,
    31'b110_1001011_0000010_0000010_0000000,
    31'b011_1111011_0000011_0100100_0000000,
    31'b101_1100011_0000000_0101000_0000000,
    31'b110_1100000_0000011_0110000_0000000,
    31'b110_0110011_0000001_1000000_0000000,
    31'b000_1111111_0000100_0000000_0000000,
    31'b101_1001101_1001000_0000000_0000000,
    31'b011_1010011_1010000_0000000_0000000,
    31'b110_1100110_1100000_0000000_0000000
  };

  localparam short_row_t GenShort [KShort] = '{
    15'b1_1000110_0010000,
    15'b0_0110101_0001000,
    15'b0_0101010_1000100,
    15'b1_0001001_0100010,
    15'b0_0000111_1100000,
    15'b0_1010000_1100001,
    15'b1_1111000_0011111
  };

  // xor of the generator rows picked by the set message bits
  function automatic long_row_t encode(input logic [15:0] msg, input logic short_sel);
    long_row_t cw;
    cw = '0;
    for (int i = 0; i < int'(KLong); i++) begin
      if (!short_sel && msg[i]) begin
        cw = cw ^ GenLong[i];
      end
    end
    for (int i = 0; i < int'(KShort); i++) begin
      if (short_sel && msg[i]) begin
        cw = cw ^ long_row_t'(GenShort[i]);
      end
    end
    return cw;
  endfunction

  // ones count, nibble counts summed
  function automatic logic [4:0] popcount31(input long_row_t v);
    logic [31:0] w;
    logic [4:0]  acc;
    logic [2:0]  nib;
    w   = {1'b0, v};
    acc = '0;
    for (int g = 0; g < 8; g++) begin
      nib = 3'(w[4*g]) + 3'(w[4*g+1]) + 3'(w[4*g+2]) + 3'(w[4*g+3]);
      acc = acc + 5'(nib);
    end
    return acc;
  endfunction

endpackage

### rtl/ml_decoder_linear_block_code.sv
// flow: an accepted request searches every candidate message of the selected code, one candidate
// per cycle through the encode and compare stages, then drains the compare stage and loads the best
// message into the output register; no new request is taken before that load, since the single
// candidate counter feeds one encode/count/compare unit
// reset: synchronous active-low rst_n, block idle, no result pending, code_select cleared
module ml_decoder_linear_block_code
  import mldlbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_code_select,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_received_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_message
);

  // control state
  state_t      state_r, state_nxt;
  logic        code_sel_r;      // mode register
  logic        mode_r;          // mode frozen for the request in flight
  logic        out_valid_r;
  logic        pipe_vld_r;      // candidate sitting in the compare stage

  // payload
  logic [30:0] rx_r;            // received word, masked for the short code
  logic [15:0] cand_r;          // candidate being encoded
  logic [15:0] cand_d_r;        // candidate in the compare stage
  logic [30:0] diff_r;          // received xor candidate codeword
  logic [7:0]  best_dist_r;
  logic [15:0] best_r;
  logic [15:0] out_message_r;

  // sequencer outputs
  logic        accept;
  logic        issue;           // encode stage takes cand_r this cycle
  logic        load_out;        // final best goes to the output register
  logic [15:0] cand_last;
  logic [4:0]  cand_dist;
  logic        better;

  assign accept    = in_valid && in_ready;
  assign cand_last = mode_r ? CandLastShort : CandLastLong;

  // distance unit: strict compare keeps the lowest message on a tie
  assign cand_dist = popcount31(diff_r);
  assign better    = pipe_vld_r && ({3'b000, cand_dist} < best_dist_r);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: search every candidate, drain the compare stage, then hand over
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        issue = 1'b1;
        if (cand_r == cand_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last candidate is compared on this edge
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_sel_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pipe_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        code_sel_r <= cfg_code_select;
      end
      pipe_vld_r <= issue;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r      <= code_sel_r;
      rx_r        <= code_sel_r ? {16'h0000, in_received_word[14:0]} : in_received_word;
      cand_r      <= '0;
      best_dist_r <= DistStart;
      best_r      <= '0;
    end else begin
      if (issue) begin
        cand_r <= cand_r + 16'd1;
      end
      if (better) begin
        best_dist_r <= {3'b000, cand_dist};
        best_r      <= cand_d_r;
      end
    end
    // encode stage
    diff_r   <= rx_r ^ encode(cand_r, mode_r);
    cand_d_r <= cand_r;
    if (load_out) begin
      out_message_r <= best_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_message = out_message_r;

endmodule

### rtl/mldlbc_checker.sv
`include "ml_decoder_linear_block_code_macros.svh"

module mldlbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_message
);

  // ready drops once a request is taken
  `MLDLBC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // a result does not rise straight after a request is taken
  `MLDLBC_ASSERT_NXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "early result")

  // a stalled result holds
  `MLDLBC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_message),
    "result dropped or changed under stall")

endmodule

bind ml_decoder_linear_block_code mldlbc_checker u_mldlbc_checker (.*);
